FILE: src/char_multiset_containment_unit_macros.svh
// Assertion helpers for the character multiset containment unit.
// Each macro expects clk and arst_n in scope.
`ifndef CHAR_MULTISET_CONTAINMENT_UNIT_MACROS_SVH
`define CHAR_MULTISET_CONTAINMENT_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define CMCU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CMCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/cmcu_pkg.sv
package cmcu_pkg;

	// Item modes
	localparam logic [1:0] MODE_SRC  = 2'd0;
	localparam logic [1:0] MODE_TGT  = 2'd1;
	localparam logic [1:0] MODE_EVAL = 2'd2;

	// Character that is never counted
	localparam logic [7:0] SPACE_CODE = 8'h20;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch;       // capture address of accepted character
		logic bump_src;    // write incremented source count
		logic bump_tgt;    // write incremented target count
		logic eval_rd;     // read entry at scan index and advance
		logic eval_clear;  // clear histograms and scan state
		logic load_out;    // load answer register
	} cmcu_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic char_ok;     // character is countable
		logic idx_last;    // scan index at last entry
	} cmcu_status_t;

endpackage

FILE: src/cmcu_ram.sv
module cmcu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/cmcu_datapath.sv
module cmcu_datapath #(
	parameter int COUNT_WIDTH   = 16,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmcu_pkg::cmcu_cmd_t   cmd,
	input  logic [7:0]            char_code,
	output cmcu_pkg::cmcu_status_t status,
	output logic                  answer
);
	import cmcu_pkg::*;

	localparam int AW = $clog2(ALPHABET_SIZE);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [AW-1:0]            char_addr;
	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            addr_q;
	logic [AW-1:0]            idx_q;
	logic [ALPHABET_SIZE-1:0] src_vld_q;
	logic [ALPHABET_SIZE-1:0] tgt_vld_q;
	logic                     src_vld_s1;
	logic                     tgt_vld_s1;
	logic                     cmp_s1;
	logic                     fail_q;
	logic [COUNT_WIDTH-1:0]   src_rdata;
	logic [COUNT_WIDTH-1:0]   tgt_rdata;
	logic [COUNT_WIDTH-1:0]   src_cur;
	logic [COUNT_WIDTH-1:0]   tgt_cur;
	logic [COUNT_WIDTH-1:0]   src_nxt;
	logic [COUNT_WIDTH-1:0]   tgt_nxt;

	assign char_addr = char_code[AW-1:0];
	assign rd_addr   = cmd.eval_rd ? idx_q : char_addr;

	// Flag countable characters
	assign status.char_ok  = (char_code != SPACE_CODE) &&
		({1'b0, char_code} < 9'(ALPHABET_SIZE));
	assign status.idx_last = (idx_q == AW'(ALPHABET_SIZE - 1));

	// Entries never written since the last clear read as zero
	assign src_cur = src_vld_s1 ? src_rdata : '0;
	assign tgt_cur = tgt_vld_s1 ? tgt_rdata : '0;

	// Saturating increment
	assign src_nxt = (src_cur == COUNT_MAX) ? src_cur : src_cur + COUNT_WIDTH'(1);
	assign tgt_nxt = (tgt_cur == COUNT_MAX) ? tgt_cur : tgt_cur + COUNT_WIDTH'(1);

	cmcu_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET_SIZE)) u_src_ram (
		.clk   (clk),
		.we    (cmd.bump_src),
		.waddr (addr_q),
		.wdata (src_nxt),
		.raddr (rd_addr),
		.rdata (src_rdata)
	);

	cmcu_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET_SIZE)) u_tgt_ram (
		.clk   (clk),
		.we    (cmd.bump_tgt),
		.waddr (addr_q),
		.wdata (tgt_nxt),
		.raddr (rd_addr),
		.rdata (tgt_rdata)
	);

	// Hold the address of the character being counted
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			addr_q <= char_addr;
		end
		src_vld_s1 <= src_vld_q[rd_addr];
		tgt_vld_s1 <= tgt_vld_q[rd_addr];
	end

	// Track written entries, scan index and comparison result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_vld_q <= '0;
			tgt_vld_q <= '0;
			idx_q     <= '0;
			cmp_s1    <= 1'b0;
			fail_q    <= 1'b0;
		end else begin
			cmp_s1 <= cmd.eval_rd;
			if (cmd.eval_clear) begin
				src_vld_q <= '0;
				tgt_vld_q <= '0;
				idx_q     <= '0;
				fail_q    <= 1'b0;
			end else begin
				if (cmd.bump_src) begin
					src_vld_q[addr_q] <= 1'b1;
				end
				if (cmd.bump_tgt) begin
					tgt_vld_q[addr_q] <= 1'b1;
				end
				if (cmd.eval_rd) begin
					idx_q <= status.idx_last ? '0 : idx_q + AW'(1);
				end
				if (cmp_s1 && (tgt_cur > src_cur)) begin
					fail_q <= 1'b1;
				end
			end
		end
	end

	// Answer register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			answer <= !fail_q;
		end
	end
endmodule

FILE: src/cmcu_ctrl.sv
module cmcu_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             mode,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  cmcu_pkg::cmcu_status_t status,
	output cmcu_pkg::cmcu_cmd_t    cmd
);
	import cmcu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUMP_SRC,
		ST_BUMP_TGT,
		ST_EVAL_RUN,
		ST_EVAL_CMP,
		ST_EVAL_OUT
	} state_t;

	state_t state_q;
	logic   in_xfer;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// Decode commands from state
	always_comb begin
		cmd            = '0;
		cmd.latch      = in_xfer;
		cmd.bump_src   = (state_q == ST_BUMP_SRC);
		cmd.bump_tgt   = (state_q == ST_BUMP_TGT);
		cmd.eval_rd    = (state_q == ST_EVAL_RUN);
		cmd.load_out   = (state_q == ST_EVAL_OUT) && out_free;
		cmd.eval_clear = cmd.load_out;
	end

	// Advance state and hold output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (mode)
							MODE_SRC: begin
								if (status.char_ok) state_q <= ST_BUMP_SRC;
							end
							MODE_TGT: begin
								if (status.char_ok) state_q <= ST_BUMP_TGT;
							end
							MODE_EVAL: begin
								state_q <= ST_EVAL_RUN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_BUMP_SRC, ST_BUMP_TGT: begin
					state_q <= ST_IDLE;
				end
				ST_EVAL_RUN: begin
					if (status.idx_last) state_q <= ST_EVAL_CMP;
				end
				ST_EVAL_CMP: begin
					state_q <= ST_EVAL_OUT;
				end
				ST_EVAL_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: src/char_multiset_containment_unit.sv
// Character multiset containment unit.
// Input channel (in_valid/in_ready, mode, char_code): mode 0 counts char_code
// in the source histogram, mode 1 in the target histogram, mode 2 evaluates.
// Spaces, codes outside the alphabet and mode 3 are taken and dropped.
// Output channel (out_valid/out_ready, answer): one transfer per evaluate,
// answer 1 when no byte occurs more often in the target than in the source.
// Counting a character is a registered RAM read, then the saturating write
// back; the next item is taken in the cycle after the write.
// An evaluate scans all ALPHABET_SIZE entries of both RAMs, one per cycle,
// then compares the last entry and loads the answer; the next item is taken
// in the cycle after the load. Both histograms are then empty.
// Reset empties both histograms at once through per-entry valid flags, so no
// clearing pass follows reset; the block takes items on the first cycle.
// The answer sits in an output register; while the receiver stalls, counting
// goes on, and an evaluate waits at its end until the register is free.
module char_multiset_containment_unit #(
	parameter int COUNT_WIDTH   = 16,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       answer
);
	import cmcu_pkg::*;

	cmcu_cmd_t    cmd;
	cmcu_status_t status;

	cmcu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cmcu_datapath #(
		.COUNT_WIDTH   (COUNT_WIDTH),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.char_code (char_code),
		.status    (status),
		.answer    (answer)
	);

`include "char_multiset_containment_unit_macros.svh"

	// Scan never overlaps an input transfer
	`CMCU_ASSERT_SAME(a_scan_blocks_input, cmd.eval_rd, !in_ready, "input taken during scan")
	// Answer load only into a free output register
	`CMCU_ASSERT_SAME(a_load_when_free, cmd.load_out, (!out_valid || out_ready), "answer overwritten")
	// Loaded answer is presented next cycle
	`CMCU_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid, "loaded answer not presented")
	// Evaluate transfer starts the scan
	`CMCU_ASSERT_NEXT(a_eval_starts, (in_valid && in_ready && mode == MODE_EVAL), cmd.eval_rd, "scan not started")
endmodule
